// ===== src/gfm_pkg.sv =====
// Package for the gaze fixation monitor: register file layout, stream
// packing offsets, queue record and prompt codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gfm_pkg;

  // Stream widths: input tdata 137 field bits padded to 144, output 8.
  localparam int IN_W  = 144;
  localparam int OUT_W = 8;

  // Input tdata field offsets, lowest bit first.
  localparam int IN_LGX_LSB   = 0;
  localparam int IN_LGY_LSB   = 16;
  localparam int IN_RGX_LSB   = 32;
  localparam int IN_RGY_LSB   = 48;
  localparam int IN_LVAL_LSB  = 64;
  localparam int IN_RVAL_LSB  = 67;
  localparam int IN_LDIST_LSB = 70;
  localparam int IN_RDIST_LSB = 86;
  localparam int IN_CX_LSB    = 102;
  localparam int IN_CY_LSB    = 119;
  localparam int IN_START_BIT = 136;

  // Configuration port.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_GAZE_OFFSET       = 3'd0,
    REG_GAZE_INV_SCALE    = 3'd1,
    REG_ASPECT_RATIO      = 3'd2,
    REG_FIXATION_RADIUS   = 3'd3,
    REG_BLINK_LIMIT       = 3'd4,
    REG_SACCADE_LIMIT     = 3'd5,
    REG_CORRECTION_BLOCKS = 3'd6,
    REG_NONE              = 3'd7
  } gfm_reg_idx_t;

  localparam logic signed [17:0] RST_GAZE_OFFSET     = 18'sd0;
  localparam logic [15:0]        RST_GAZE_INV_SCALE  = 16'd256;
  localparam logic [15:0]        RST_ASPECT_RATIO    = 16'd256;
  localparam logic [16:0]        RST_FIXATION_RADIUS = 17'd6554;
  localparam logic [15:0]        RST_BLINK_LIMIT     = 16'd10;
  localparam logic [15:0]        RST_SACCADE_LIMIT   = 16'd10;
  localparam logic [15:0]        RST_CORR_BLOCKS     = 16'd64;

  // Eye distance window, as a sum of both eyes in mm.
  localparam logic [16:0] CLOSE_SUM = 17'd1100;
  localparam logic [16:0] FAR_SUM   = 17'd1200;
  localparam logic [15:0] SAT16     = 16'hFFFF;
  localparam logic [30:0] MAG_CAP   = 31'h7FFF_FFFF;

  localparam int Q_DEPTH = 2;

  typedef enum logic [2:0] {
    PROMPT_NONE   = 3'd0,
    PROMPT_FIXATE = 3'd1,
    PROMPT_OK     = 3'd2,
    PROMPT_THREE  = 3'd3,
    PROMPT_TWO    = 3'd4,
    PROMPT_ONE    = 3'd5,
    PROMPT_AWAY   = 3'd6,
    PROMPT_CLOSER = 3'd7
  } gfm_prompt_t;

  typedef struct packed {
    logic signed [17:0] gaze_offset;
    logic [15:0]        gaze_inv_scale;
    logic [15:0]        aspect_ratio;
    logic [16:0]        fixation_radius;
    logic [15:0]        blink_limit;
    logic [15:0]        saccade_limit;
    logic [15:0]        correction_blocks;
  } gfm_cfg_t;

  // Classified sample passed from front to back.
  typedef struct packed {
    logic left_ok;
    logic right_ok;
    logic outside;
    logic dist_close;
    logic dist_far;
    logic start;
  } gfm_item_t;

endpackage

`default_nettype wire

// ===== src/gfm_regs.sv =====
// APB-style configuration register file for the gaze fixation monitor.
// Depends on gfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfm_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [gfm_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [gfm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [gfm_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready,
  output gfm_pkg::gfm_cfg_t               cfg
);

  gfm_pkg::gfm_cfg_t     cfg_r;
  gfm_pkg::gfm_reg_idx_t idx;
  logic                  wr_en;

  assign idx        = gfm_pkg::gfm_reg_idx_t'(cfg_paddr[CFG_AW_TOP:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  localparam int CFG_AW_TOP = gfm_pkg::CFG_AW - 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gaze_offset       <= gfm_pkg::RST_GAZE_OFFSET;
      cfg_r.gaze_inv_scale    <= gfm_pkg::RST_GAZE_INV_SCALE;
      cfg_r.aspect_ratio      <= gfm_pkg::RST_ASPECT_RATIO;
      cfg_r.fixation_radius   <= gfm_pkg::RST_FIXATION_RADIUS;
      cfg_r.blink_limit       <= gfm_pkg::RST_BLINK_LIMIT;
      cfg_r.saccade_limit     <= gfm_pkg::RST_SACCADE_LIMIT;
      cfg_r.correction_blocks <= gfm_pkg::RST_CORR_BLOCKS;
    end else if (wr_en) begin
      unique case (idx)
        gfm_pkg::REG_GAZE_OFFSET:       cfg_r.gaze_offset       <= $signed(cfg_pwdata[17:0]);
        gfm_pkg::REG_GAZE_INV_SCALE:    cfg_r.gaze_inv_scale    <= cfg_pwdata[15:0];
        gfm_pkg::REG_ASPECT_RATIO:      cfg_r.aspect_ratio      <= cfg_pwdata[15:0];
        gfm_pkg::REG_FIXATION_RADIUS:   cfg_r.fixation_radius   <= cfg_pwdata[16:0];
        gfm_pkg::REG_BLINK_LIMIT:       cfg_r.blink_limit       <= cfg_pwdata[15:0];
        gfm_pkg::REG_SACCADE_LIMIT:     cfg_r.saccade_limit     <= cfg_pwdata[15:0];
        gfm_pkg::REG_CORRECTION_BLOCKS: cfg_r.correction_blocks <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gfm_pkg::REG_GAZE_OFFSET:       cfg_prdata = {14'd0, cfg_r.gaze_offset};
      gfm_pkg::REG_GAZE_INV_SCALE:    cfg_prdata = {16'd0, cfg_r.gaze_inv_scale};
      gfm_pkg::REG_ASPECT_RATIO:      cfg_prdata = {16'd0, cfg_r.aspect_ratio};
      gfm_pkg::REG_FIXATION_RADIUS:   cfg_prdata = {15'd0, cfg_r.fixation_radius};
      gfm_pkg::REG_BLINK_LIMIT:       cfg_prdata = {16'd0, cfg_r.blink_limit};
      gfm_pkg::REG_SACCADE_LIMIT:     cfg_prdata = {16'd0, cfg_r.saccade_limit};
      gfm_pkg::REG_CORRECTION_BLOCKS: cfg_prdata = {16'd0, cfg_r.correction_blocks};
      default:                        cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/gfm_front.sv =====
// Front end of the gaze fixation monitor: accepts samples and classifies
// them (validity, distance window, gaze outside radius). Depends on gfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfm_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [gfm_pkg::IN_W-1:0] in_tdata,
  input  gfm_pkg::gfm_cfg_t             cfg,
  output logic                          q_wr_valid,
  input  wire logic                     q_wr_ready,
  output gfm_pkg::gfm_item_t            q_wr_item
);

  typedef enum logic [5:0] {
    F_IDLE  = 6'b000001,
    F_AVG   = 6'b000010,
    F_SCALE = 6'b000100,
    F_DIFF  = 6'b001000,
    F_SQR   = 6'b010000,
    F_PUSH  = 6'b100000
  } gfm_front_state_t;

  gfm_front_state_t state_r, state_nxt;

  // Sample capture
  logic [16:0]        sum_x_r, sum_y_r, cx_r, cy_r;
  gfm_pkg::gfm_item_t item_r;
  // Datapath stages
  logic [16:0]        avg_x_r, avg_y_r;
  logic signed [26:0] gx_r, gy_r;
  logic [30:0]        mag_x_r;
  logic [26:0]        mag_y_r;
  logic [61:0]        sq_x_r;
  logic [53:0]        sq_y_r;
  logic [33:0]        r2_r;

  logic               accept;
  logic [16:0]        dsum;
  logic signed [18:0] diff_x, diff_y, off_ext;
  logic signed [35:0] prod_x, prod_y;
  logic signed [27:0] dx, dy;
  logic signed [44:0] prod_a;
  logic signed [36:0] dxa;
  logic [36:0]        abs_x;
  logic [27:0]        abs_y;
  logic [62:0]        d2;

  // floor(s * 32768 / 65535): quotient from the high half, then fold the
  // remainder back in with at most two corrections.
  function automatic logic [16:0] avg_div(input logic [16:0] s);
    logic [16:0] q;
    logic [16:0] rem;
    q   = {1'b0, s[16:1]};
    rem = {1'b0, s[0], 15'd0} + q;
    if (rem >= 17'd131070)
      avg_div = q + 17'd2;
    else if (rem >= 17'd65535)
      avg_div = q + 17'd1;
    else
      avg_div = q;
  endfunction

  assign in_tready = (state_r == F_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign dsum      = {1'b0, in_tdata[gfm_pkg::IN_LDIST_LSB +: 16]}
                   + {1'b0, in_tdata[gfm_pkg::IN_RDIST_LSB +: 16]};

  assign q_wr_valid = (state_r == F_PUSH);
  assign q_wr_item  = '{left_ok:    item_r.left_ok,
                        right_ok:   item_r.right_ok,
                        outside:    (d2 > {29'd0, r2_r}),
                        dist_close: item_r.dist_close,
                        dist_far:   item_r.dist_far,
                        start:      item_r.start};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (accept) state_nxt = F_AVG;
      F_AVG:   state_nxt = F_SCALE;
      F_SCALE: state_nxt = F_DIFF;
      F_DIFF:  state_nxt = F_SQR;
      F_SQR:   state_nxt = F_PUSH;
      F_PUSH:  if (q_wr_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= F_IDLE;
    else
      state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_x_r <= {1'b0, in_tdata[gfm_pkg::IN_LGX_LSB +: 16]}
               + {1'b0, in_tdata[gfm_pkg::IN_RGX_LSB +: 16]};
      sum_y_r <= {1'b0, in_tdata[gfm_pkg::IN_LGY_LSB +: 16]}
               + {1'b0, in_tdata[gfm_pkg::IN_RGY_LSB +: 16]};
      cx_r    <= in_tdata[gfm_pkg::IN_CX_LSB +: 17];
      cy_r    <= in_tdata[gfm_pkg::IN_CY_LSB +: 17];
      item_r.left_ok    <= (in_tdata[gfm_pkg::IN_LVAL_LSB +: 3] < 3'd2);
      item_r.right_ok   <= (in_tdata[gfm_pkg::IN_RVAL_LSB +: 3] < 3'd2);
      item_r.outside    <= 1'b0;
      item_r.dist_close <= (dsum < gfm_pkg::CLOSE_SUM);
      item_r.dist_far   <= (dsum >= gfm_pkg::FAR_SUM);
      item_r.start      <= in_tdata[gfm_pkg::IN_START_BIT];
    end
  end

  // Stage math: stages read prior-stage registers, captured centre and cfg.
  always_comb begin
    off_ext = {cfg.gaze_offset[17], cfg.gaze_offset};
    diff_x  = $signed({2'b00, avg_x_r}) - off_ext;
    diff_y  = $signed({2'b00, avg_y_r}) - off_ext;
    prod_x  = diff_x * $signed({1'b0, cfg.gaze_inv_scale});
    prod_y  = diff_y * $signed({1'b0, cfg.gaze_inv_scale});
    dx      = $signed({gx_r[26], gx_r}) - $signed({11'd0, cx_r});
    dy      = $signed({gy_r[26], gy_r}) - $signed({11'd0, cy_r});
    prod_a  = dx * $signed({1'b0, cfg.aspect_ratio});
    dxa     = prod_a[44:8];
    abs_x   = dxa[36] ? 37'(-dxa) : 37'(dxa);
    abs_y   = dy[27] ? 28'(-dy) : 28'(dy);
    d2      = {1'b0, sq_x_r} + {9'd0, sq_y_r};
  end

  always_ff @(posedge clk) begin
    avg_x_r <= avg_div(sum_x_r);
    avg_y_r <= avg_div(sum_y_r);
    // Arithmetic shift floors toward minus infinity.
    gx_r    <= prod_x[34:8];
    gy_r    <= prod_y[34:8];
    mag_x_r <= (abs_x > {6'd0, gfm_pkg::MAG_CAP}) ? gfm_pkg::MAG_CAP : abs_x[30:0];
    mag_y_r <= abs_y[26:0];
    sq_x_r  <= mag_x_r * mag_x_r;
    sq_y_r  <= mag_y_r * mag_y_r;
    r2_r    <= cfg.fixation_radius * cfg.fixation_radius;
  end

endmodule

`default_nettype wire

// ===== src/gfm_queue.sv =====
// Two-entry queue of classified samples between front and back.
// Depends on gfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  gfm_pkg::gfm_item_t wr_item,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output gfm_pkg::gfm_item_t rd_item
);

  localparam int PW = $clog2(gfm_pkg::Q_DEPTH);
  localparam int CW = $clog2(gfm_pkg::Q_DEPTH + 1);

  gfm_pkg::gfm_item_t mem_r [gfm_pkg::Q_DEPTH];
  logic [PW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]      count_r;
  logic               push, pop;

  assign wr_ready = (count_r != CW'(gfm_pkg::Q_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (push)
      mem_r[wr_ptr_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == PW'(gfm_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)
        rd_ptr_r <= (rd_ptr_r == PW'(gfm_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)
        count_r <= count_r + 1'b1;
      else if (pop && !push)
        count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== src/gfm_back.sv =====
// Back end of the gaze fixation monitor: blink, saccade and correction
// state update, one queued sample per cycle unless the output stalls,
// into the output register. Depends on gfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfm_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  gfm_pkg::gfm_cfg_t              cfg,
  input  wire logic                      q_rd_valid,
  output logic                           q_rd_ready,
  input  gfm_pkg::gfm_item_t             q_rd_item,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [gfm_pkg::OUT_W-1:0]      out_tdata
);

  logic        lost_left_r, lost_right_r, fixated_r, correcting_r;
  logic [15:0] blink_count_r, saccade_count_r, correction_count_r;
  logic        out_valid_r;
  logic [gfm_pkg::OUT_W-1:0] out_data_r;

  logic        lost_left_nxt, lost_right_nxt, fixated_nxt, correcting_nxt;
  logic [15:0] blink_count_nxt, saccade_count_nxt, correction_count_nxt;
  logic        pop, eyes_invalid, looking_away, good, corr_on, dist_mid;
  logic [15:0] cc_inc, thr1, thr2, thr3;
  logic [17:0] t3;
  gfm_pkg::gfm_prompt_t prompt;

  assign pop        = q_rd_valid & (~out_valid_r | out_tready);
  assign q_rd_ready = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    lost_left_nxt        = lost_left_r;
    lost_right_nxt       = lost_right_r;
    blink_count_nxt      = blink_count_r;
    saccade_count_nxt    = saccade_count_r;
    correction_count_nxt = correction_count_r;
    looking_away         = 1'b0;
    good                 = 1'b0;
    prompt               = gfm_pkg::PROMPT_NONE;

    // Blink tracking
    if (lost_left_r || lost_right_r) begin
      if (q_rd_item.left_ok && q_rd_item.right_ok) begin
        lost_left_nxt   = 1'b0;
        lost_right_nxt  = 1'b0;
        blink_count_nxt = '0;
      end else if (blink_count_r != gfm_pkg::SAT16) begin
        blink_count_nxt = blink_count_r + 16'd1;
      end
    end
    if (!q_rd_item.left_ok)  lost_left_nxt  = 1'b1;
    if (!q_rd_item.right_ok) lost_right_nxt = 1'b1;
    eyes_invalid = (blink_count_nxt > cfg.blink_limit);

    // Saccade tracking
    if (q_rd_item.outside) begin
      if (saccade_count_r <= cfg.saccade_limit) begin
        if (saccade_count_r != gfm_pkg::SAT16)
          saccade_count_nxt = saccade_count_r + 16'd1;
      end else begin
        looking_away = 1'b1;
      end
    end else begin
      saccade_count_nxt = '0;
    end

    fixated_nxt = ~(eyes_invalid | looking_away);

    // Correction mode: prompt from the count before this sample
    corr_on  = correcting_r | q_rd_item.start;
    t3       = {2'b00, cfg.correction_blocks} + {1'b0, cfg.correction_blocks, 1'b0};
    thr3     = t3[17:2];
    thr2     = {1'b0, cfg.correction_blocks[15:1]};
    thr1     = {2'b00, cfg.correction_blocks[15:2]};
    cc_inc   = (correction_count_r != gfm_pkg::SAT16) ? correction_count_r + 16'd1
                                                      : correction_count_r;
    dist_mid = ~q_rd_item.dist_close & ~q_rd_item.dist_far;
    correcting_nxt = corr_on;
    if (corr_on) begin
      if (correction_count_r >= thr3)      prompt = gfm_pkg::PROMPT_ONE;
      else if (correction_count_r >= thr2) prompt = gfm_pkg::PROMPT_TWO;
      else if (correction_count_r >= thr1) prompt = gfm_pkg::PROMPT_THREE;
      else if (correction_count_r != '0)   prompt = gfm_pkg::PROMPT_OK;
      else                                 prompt = gfm_pkg::PROMPT_FIXATE;

      if (fixated_nxt && dist_mid) begin
        good = 1'b1;
        correction_count_nxt = cc_inc;
        if (cc_inc >= cfg.correction_blocks) begin
          correcting_nxt       = 1'b0;
          correction_count_nxt = '0;
        end
      end else if (fixated_nxt && q_rd_item.dist_close) begin
        prompt               = gfm_pkg::PROMPT_AWAY;
        correction_count_nxt = '0;
      end else if (fixated_nxt && q_rd_item.dist_far) begin
        prompt               = gfm_pkg::PROMPT_CLOSER;
        correction_count_nxt = '0;
      end else begin
        correction_count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lost_left_r        <= 1'b0;
      lost_right_r       <= 1'b0;
      blink_count_r      <= '0;
      saccade_count_r    <= '0;
      fixated_r          <= 1'b1;
      correcting_r       <= 1'b0;
      correction_count_r <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      if (pop) begin
        lost_left_r        <= lost_left_nxt;
        lost_right_r       <= lost_right_nxt;
        blink_count_r      <= blink_count_nxt;
        saccade_count_r    <= saccade_count_nxt;
        fixated_r          <= fixated_nxt;
        correcting_r       <= correcting_nxt;
        correction_count_r <= correction_count_nxt;
        out_valid_r        <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop)
      out_data_r <= {good, prompt, correcting_nxt, looking_away, eyes_invalid,
                     ~fixated_nxt};
  end

  // fixated_r mirrors the flag carried out with each result
  logic unused_fix;
  assign unused_fix = fixated_r;

endmodule

`default_nettype wire

// ===== src/gaze_fixation_monitor_top.sv =====
// Top level of the gaze fixation monitor: configuration registers, front
// classifier, sample queue and back-end state update. Depends on gfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one binocular eye-tracker sample per transfer and returns one
// status result per sample. The front sequencer steps through each
// sample (capture, average, offset and scale, centre difference, squaring,
// radius compare and queue write) and takes no new sample until the queue
// write is done; the back end retires a queued sample whenever its output
// register is free or being read, and a two-entry queue plus the output
// register let the result side stall before the front is blocked.
// Configuration writes are taken at any time but should be made while no
// sample is in flight.
module gaze_fixation_monitor_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // [15:0] left_gaze_x, [31:16] left_gaze_y, [47:32] right_gaze_x,
  // [63:48] right_gaze_y, [66:64] left_validity, [69:67] right_validity,
  // [85:70] left_distance, [101:86] right_distance, [118:102] center_x,
  // [135:119] center_y, [136] start_correction, [143:137] zero
  input  wire logic [gfm_pkg::IN_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [0] fixation_violated, [1] eyes_invalid, [2] looking_away,
  // [3] correction_active, [6:4] prompt_code, [7] distance_good
  output logic [gfm_pkg::OUT_W-1:0]       out_tdata,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [gfm_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [gfm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [gfm_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  gfm_pkg::gfm_cfg_t  cfg;
  gfm_pkg::gfm_item_t wr_item, rd_item;
  logic               wr_valid, wr_ready, rd_valid, rd_ready;

  gfm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  gfm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg        (cfg),
    .q_wr_valid (wr_valid),
    .q_wr_ready (wr_ready),
    .q_wr_item  (wr_item)
  );

  gfm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_item  (wr_item),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_item  (rd_item)
  );

  gfm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_rd_valid (rd_valid),
    .q_rd_ready (rd_ready),
    .q_rd_item  (rd_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== src/gfm_checker.sv =====
// Port-level checker for the gaze fixation monitor result stream, bound
// to the top level. Depends on gfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfm_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     out_tvalid,
  input wire logic                     out_tready,
  input wire logic [gfm_pkg::OUT_W-1:0] out_tdata
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // Nothing comes out right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Violation follows exactly from lost eyes or looking away.
  a_violation: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[1] | out_tdata[2])))
    else $error("fixation flag disagrees with eye and saccade flags");

  // Distance prompts only while fixated and still correcting.
  a_dist_prompt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[6:4] == gfm_pkg::PROMPT_AWAY ||
                   out_tdata[6:4] == gfm_pkg::PROMPT_CLOSER)
    |-> out_tdata[3] && !out_tdata[0] && !out_tdata[7])
    else $error("distance prompt with inconsistent flags");

endmodule

bind gaze_fixation_monitor_top gfm_checker u_gfm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== verif/gfm_status_scoreboard.sv =====
// Scoreboard for the gaze fixation monitor: a bit-exact status predictor
// with its own register and tracking state, and the queue of expected status.
// Depends on gfm_pkg for register indexes, reset values and prompt codes.
`timescale 1ns / 1ps

package gfm_status_scoreboard_pkg;
  import gfm_pkg::*;

  typedef struct {
    logic [15:0] left_gaze_x;
    logic [15:0] left_gaze_y;
    logic [15:0] right_gaze_x;
    logic [15:0] right_gaze_y;
    logic [2:0]  left_validity;
    logic [2:0]  right_validity;
    logic [15:0] left_distance;
    logic [15:0] right_distance;
    logic [16:0] center_x;
    logic [16:0] center_y;
    logic        start_correction;
  } gaze_sample_t;

  typedef struct {
    logic        fixation_violated;
    logic        eyes_invalid;
    logic        looking_away;
    logic        correction_active;
    gfm_prompt_t prompt_code;
    logic        distance_good;
  } gaze_status_t;

  class fixation_scoreboard;
    localparam int REPORT_CAP = 100;
    localparam longint unsigned MAG_LIMIT = 64'h7FFF_FFFF;

    logic signed [17:0] gaze_offset;
    logic [15:0]        gaze_inv_scale;
    logic [15:0]        aspect_ratio;
    logic [16:0]        fixation_radius;
    logic [15:0]        blink_limit;
    logic [15:0]        saccade_limit;
    logic [15:0]        correction_blocks;

    logic        lost_left;
    logic        lost_right;
    logic [15:0] blink_count;
    logic [15:0] saccade_count;
    logic        fixated;
    logic        correcting;
    logic [15:0] correction_count;

    gaze_status_t expected_status_q[$];
    int failures;
    int reported;

    function new();
      gaze_offset       = RST_GAZE_OFFSET;
      gaze_inv_scale    = RST_GAZE_INV_SCALE;
      aspect_ratio      = RST_ASPECT_RATIO;
      fixation_radius   = RST_FIXATION_RADIUS;
      blink_limit       = RST_BLINK_LIMIT;
      saccade_limit     = RST_SACCADE_LIMIT;
      correction_blocks = RST_CORR_BLOCKS;
      lost_left         = 1'b0;
      lost_right        = 1'b0;
      blink_count       = '0;
      saccade_count     = '0;
      fixated           = 1'b1;
      correcting        = 1'b0;
      correction_count  = '0;
      failures          = 0;
      reported          = 0;
    endfunction

    function void set_reg(gfm_reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_GAZE_OFFSET:       gaze_offset       = value[17:0];
        REG_GAZE_INV_SCALE:    gaze_inv_scale    = value[15:0];
        REG_ASPECT_RATIO:      aspect_ratio      = value[15:0];
        REG_FIXATION_RADIUS:   fixation_radius   = value[16:0];
        REG_BLINK_LIMIT:       blink_limit       = value[15:0];
        REG_SACCADE_LIMIT:     saccade_limit     = value[15:0];
        REG_CORRECTION_BLOCKS: correction_blocks = value[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_status_q.size();
    endfunction

    function logic [15:0] bump(logic [15:0] c);
      return (c == SAT16) ? c : c + 16'd1;
    endfunction

    // Average both eyes into Q16, then remove offset and apply the reciprocal
    // scale; the arithmetic shift floors toward minus infinity.
    function longint gaze_axis(logic [15:0] a, logic [15:0] b);
      longint avg;
      avg = ((longint'(a) + longint'(b)) * 32768) / 65535;
      return ((avg - longint'(gaze_offset)) * longint'(gaze_inv_scale)) >>> 8;
    endfunction

    function longint unsigned clip_mag(longint v);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : v;
      return (m > MAG_LIMIT) ? MAG_LIMIT : m;
    endfunction

    function gaze_status_t predict_status(gaze_sample_t s);
      gaze_status_t     st;
      longint           gx, gy;
      longint unsigned  ax, ay, d2, r2;
      logic             lv, rv, eyes_bad, away, good;
      int unsigned      dsum, t, cc;
      gfm_prompt_t      prompt;

      gx   = gaze_axis(s.left_gaze_x, s.right_gaze_x);
      gy   = gaze_axis(s.left_gaze_y, s.right_gaze_y);
      lv   = (s.left_validity < 3'd2);
      rv   = (s.right_validity < 3'd2);
      dsum = int'(s.left_distance) + int'(s.right_distance);
      away = 1'b0;
      good = 1'b0;
      prompt = PROMPT_NONE;

      if (lost_left || lost_right) begin
        if (lv && rv) begin
          lost_left   = 1'b0;
          lost_right  = 1'b0;
          blink_count = '0;
        end else begin
          blink_count = bump(blink_count);
        end
      end
      if (!lv) lost_left = 1'b1;
      if (!rv) lost_right = 1'b1;
      eyes_bad = (blink_count > blink_limit);

      ax = clip_mag(((gx - longint'(s.center_x)) * longint'(aspect_ratio)) >>> 8);
      ay = clip_mag(gy - longint'(s.center_y));
      d2 = ax * ax + ay * ay;
      r2 = longint'(fixation_radius) * longint'(fixation_radius);
      if (d2 > r2) begin
        if (saccade_count <= saccade_limit) saccade_count = bump(saccade_count);
        else away = 1'b1;
      end else begin
        saccade_count = '0;
      end

      if (fixated && (eyes_bad || away)) fixated = 1'b0;
      else if (!fixated && !eyes_bad && !away) fixated = 1'b1;

      if (s.start_correction) correcting = 1'b1;
      if (correcting) begin
        t  = correction_blocks;
        cc = correction_count;
        if (cc >= (t * 3) / 4) prompt = PROMPT_ONE;
        else if (cc >= (t * 2) / 4) prompt = PROMPT_TWO;
        else if (cc >= t / 4) prompt = PROMPT_THREE;
        else if (cc != 0) prompt = PROMPT_OK;
        else prompt = PROMPT_FIXATE;

        if (fixated && dsum >= CLOSE_SUM && dsum < FAR_SUM) begin
          good = 1'b1;
          correction_count = bump(correction_count);
          if (int'(correction_count) >= t) begin
            correcting       = 1'b0;
            correction_count = '0;
          end
        end else if (fixated && dsum < CLOSE_SUM) begin
          prompt = PROMPT_AWAY;
          correction_count = '0;
        end else if (fixated && dsum >= FAR_SUM) begin
          prompt = PROMPT_CLOSER;
          correction_count = '0;
        end else begin
          correction_count = '0;
        end
      end

      st.fixation_violated = !fixated;
      st.eyes_invalid      = eyes_bad;
      st.looking_away      = away;
      st.correction_active = correcting;
      st.prompt_code       = prompt;
      st.distance_good     = good;
      return st;
    endfunction

    function void note_sample(gaze_sample_t s);
      expected_status_q.push_back(predict_status(s));
    endfunction

    // Count every mismatch, but print only the first batch.
    function void flag(string what, int exp_val, int act_val);
      failures++;
      if (reported < REPORT_CAP) begin
        reported++;
        $error("%s: expected %0d, got %0d", what, exp_val, act_val);
      end
    endfunction

    function void compare_field(string name, logic [2:0] exp_val, logic [2:0] act_val);
      if (exp_val !== act_val) flag(name, exp_val, act_val);
    endfunction

    function void check_status(logic [7:0] word);
      gaze_status_t want;
      if (expected_status_q.size() == 0) begin
        failures++;
        $error("status transfer 0x%02h with no sample outstanding", word);
        return;
      end
      want = expected_status_q.pop_front();
      compare_field("fixation_violated", want.fixation_violated, word[0]);
      compare_field("eyes_invalid", want.eyes_invalid, word[1]);
      compare_field("looking_away", want.looking_away, word[2]);
      compare_field("correction_active", want.correction_active, word[3]);
      compare_field("prompt_code", want.prompt_code, word[6:4]);
      compare_field("distance_good", want.distance_good, word[7]);
    endfunction
  endclass

endpackage

// ===== verif/tb_gaze_fixation_monitor_top.sv =====
// Self-checking bench for gaze_fixation_monitor_top: drives samples over the
// input stream and registers over APB, checks every status transfer against
// the scoreboard. Depends on gfm_pkg and gfm_status_scoreboard_pkg.
`timescale 1ns / 1ps

module tb_gaze_fixation_monitor_top;
  import gfm_pkg::*;
  import gfm_status_scoreboard_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SOAK_ITEMS  = 65540;
  localparam int MID         = 32768;

  typedef enum int {RUN_FIXATE, RUN_BLINK, RUN_AWAY, RUN_NOISE} run_kind_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata    = '0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  fixation_scoreboard sb = new();

  int burst_left   = 0;
  bit steady       = 1'b0;
  int stall_cycles = 0;
  int ready_mode   = 0;
  int mode_cycles  = 0;

  gaze_fixation_monitor_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // Result side: switch between always ready, coin flip and long stalls.
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      ready_mode  <= $urandom_range(0, 2);
      mode_cycles <= $urandom_range(50, 300);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    if (steady || ready_mode == 0) out_tready <= 1'b1;
    else if (ready_mode == 1) out_tready <= $urandom_range(0, 1);
    else out_tready <= ($urandom_range(0, 7) == 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_status(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic gaze_sample_t sample_of(int lgx, int lgy, int rgx, int rgy,
                                             int lval, int rval, int ldist, int rdist,
                                             int cx, int cy, int st);
    gaze_sample_t s;
    s.left_gaze_x      = lgx[15:0];
    s.left_gaze_y      = lgy[15:0];
    s.right_gaze_x     = rgx[15:0];
    s.right_gaze_y     = rgy[15:0];
    s.left_validity    = lval[2:0];
    s.right_validity   = rval[2:0];
    s.left_distance    = ldist[15:0];
    s.right_distance   = rdist[15:0];
    s.center_x         = cx[16:0];
    s.center_y         = cy[16:0];
    s.start_correction = st[0];
    return s;
  endfunction

  function automatic logic [IN_W-1:0] pack_sample(gaze_sample_t s);
    logic [IN_W-1:0] d;
    d = '0;
    d[IN_LGX_LSB +: 16]   = s.left_gaze_x;
    d[IN_LGY_LSB +: 16]   = s.left_gaze_y;
    d[IN_RGX_LSB +: 16]   = s.right_gaze_x;
    d[IN_RGY_LSB +: 16]   = s.right_gaze_y;
    d[IN_LVAL_LSB +: 3]   = s.left_validity;
    d[IN_RVAL_LSB +: 3]   = s.right_validity;
    d[IN_LDIST_LSB +: 16] = s.left_distance;
    d[IN_RDIST_LSB +: 16] = s.right_distance;
    d[IN_CX_LSB +: 17]    = s.center_x;
    d[IN_CY_LSB +: 17]    = s.center_y;
    d[IN_START_BIT]       = s.start_correction;
    return d;
  endfunction

  // Pick raw eye values whose mapped average lands near the target (Q16).
  function automatic void aim_pair(input longint target, output logic [15:0] a,
                                   output logic [15:0] b);
    longint avg, sum, lo, hi, pick;
    if (sb.gaze_inv_scale == 0) avg = $urandom_range(0, 65535);
    else avg = (target * 256) / longint'(sb.gaze_inv_scale) + longint'(sb.gaze_offset);
    sum = (avg * 65535) / 32768;
    if (sum < 0) sum = 0;
    if (sum > 131070) sum = 131070;
    lo = (sum > 65535) ? sum - 65535 : 0;
    hi = (sum < 65535) ? sum : 65535;
    pick = sum / 2 + longint'($urandom_range(0, 2000)) - 1000;
    if (pick < lo) pick = lo;
    if (pick > hi) pick = hi;
    a = 16'(pick);
    b = 16'(sum - pick);
  endfunction

  function automatic void pick_distance(output logic [15:0] ld, output logic [15:0] rd);
    int r, sum, l;
    r = $urandom_range(0, 9);
    if (r < 6) sum = $urandom_range(1100, 1199);
    else if (r < 8) sum = $urandom_range(0, 1099);
    else if (r < 9) sum = $urandom_range(1200, 1400);
    else sum = $urandom_range(1200, 131070);
    l = sum / 2 + $urandom_range(0, 40) - 20;
    if (l < 0) l = 0;
    if (l > sum) l = sum;
    if (l > 65535) l = 65535;
    if (sum - l > 65535) l = sum - 65535;
    ld = l[15:0];
    rd = 16'(sum - l);
  endfunction

  function automatic int pick_center();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 65536;
    return $urandom_range(4096, 61440);
  endfunction

  function automatic gaze_sample_t random_sample(run_kind_t kind);
    gaze_sample_t s;
    int rad, span, jx, jy, lost;
    s = sample_of($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 1), $urandom_range(0, 1), 0, 0,
                  pick_center(), pick_center(), ($urandom_range(0, 11) == 0));
    pick_distance(s.left_distance, s.right_distance);
    case (kind)
      RUN_FIXATE: begin
        rad  = sb.fixation_radius;
        span = ($urandom_range(0, 3) == 0) ? (rad * 3) / 2 : rad / 2;
        jy   = $urandom_range(0, 2 * span) - span;
        jx   = $urandom_range(0, 2 * span) - span;
        if (sb.aspect_ratio != 0) jx = (jx * 256) / int'(sb.aspect_ratio);
        aim_pair(longint'(s.center_x) + jx, s.left_gaze_x, s.right_gaze_x);
        aim_pair(longint'(s.center_y) + jy, s.left_gaze_y, s.right_gaze_y);
      end
      RUN_BLINK: begin
        lost = $urandom_range(0, 2);
        if (lost != 1) s.left_validity = $urandom_range(2, 4);
        if (lost != 0) s.right_validity = $urandom_range(2, 4);
      end
      RUN_AWAY: ;
      default: begin
        s.left_validity  = $urandom_range(0, 4);
        s.right_validity = $urandom_range(0, 4);
        s.left_distance  = $urandom_range(0, 65535);
        s.right_distance = $urandom_range(0, 65535);
        s.center_x       = $urandom_range(0, 65536);
        s.center_y       = $urandom_range(0, 65536);
        s.start_correction = $urandom_range(0, 1);
      end
    endcase
    return s;
  endfunction

  // Send one sample; bursts of random length with random gaps in between (none when steady).
  task automatic drive_sample(input gaze_sample_t s);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = steady ? SOAK_ITEMS : $urandom_range(1, 12);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tdata  = pack_sample(s);
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid  = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input gfm_reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic program_config(input int off, input int inv, input int asp, input int rad,
                                input int blink, input int sacc, input int corr);
    write_reg(REG_GAZE_OFFSET, off);
    write_reg(REG_GAZE_INV_SCALE, inv);
    write_reg(REG_ASPECT_RATIO, asp);
    write_reg(REG_FIXATION_RADIUS, rad);
    write_reg(REG_BLINK_LIMIT, blink);
    write_reg(REG_SACCADE_LIMIT, sacc);
    write_reg(REG_CORRECTION_BLOCKS, corr);
  endtask

  // Corner gaze and centre values, used under the extreme settings.
  task automatic drive_corners();
    drive_sample(sample_of(0, 0, 0, 0, 0, 0, 550, 550, 65536, 65536, 0));
    drive_sample(sample_of(65535, 65535, 65535, 65535, 1, 1, 600, 599, 0, 0, 1));
    drive_sample(sample_of(MID, MID, MID, MID, 0, 0, 575, 575, MID, MID, 0));
    drive_sample(sample_of(0, 65535, 65535, 0, 0, 1, 575, 575, 0, 65536, 0));
  endtask

  task automatic run_random(input int count);
    int left, len, r;
    run_kind_t kind;
    left = count;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        kind = RUN_FIXATE;
        len  = $urandom_range(1, 30);
      end else if (r < 78) begin
        kind = RUN_BLINK;
        len  = $urandom_range(1, 25);
      end else if (r < 93) begin
        kind = RUN_AWAY;
        len  = $urandom_range(1, 25);
      end else begin
        kind = RUN_NOISE;
        len  = $urandom_range(1, 3);
      end
      if (len > left) len = left;
      repeat (len) drive_sample(random_sample(kind));
      left -= len;
    end
  endtask

  initial begin
    int ph;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Short correction and low limits so every prompt shows up quickly.
    program_config(0, 256, 256, 6554, 2, 2, 4);
    drive_sample(sample_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drive_sample(sample_of(65535, 65535, 65535, 65535, 4, 4, 65535, 65535,
                           65536, 65536, 1));
    drive_sample(sample_of(MID, MID, MID, MID, 1, 1, 550, 550, MID, MID, 0));
    drive_sample(sample_of(MID, MID, MID, MID, 0, 0, 600, 599, MID, MID, 0));
    drive_sample(sample_of(MID, MID, MID, MID, 1, 0, 575, 575, MID, MID, 0));
    drive_sample(sample_of(MID, MID, MID, MID, 0, 1, 560, 570, MID, MID, 0));
    drive_sample(sample_of(MID, MID, MID, MID, 0, 0, 549, 550, MID, MID, 1));
    // second request while already correcting
    drive_sample(sample_of(MID, MID, MID, MID, 0, 0, 600, 600, MID, MID, 1));
    drive_sample(sample_of(MID, MID, MID, MID, 0, 2, 575, 575, MID, MID, 0));
    drive_sample(sample_of(MID, MID, MID, MID, 0, 3, 575, 575, MID, MID, 0));
    drive_sample(sample_of(MID, MID, MID, MID, 3, 4, 575, 575, MID, MID, 0));
    drive_sample(sample_of(MID, MID, MID, MID, 4, 0, 575, 575, MID, MID, 0));
    drive_sample(sample_of(MID, MID, MID, MID, 0, 0, 575, 575, MID, MID, 1));
    repeat (4) drive_sample(sample_of(0, 0, 0, 0, 0, 0, 575, 575, 65536, 65536, 0));
    drive_sample(sample_of(MID, MID, MID, MID, 1, 1, 575, 575, MID, MID, 0));
    drive_sample(sample_of(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1, 0, 16'hAAAA,
                           16'h5555, 17'h0AAAA, 17'h15555, 0));
    drain();

    program_config(-65536, 65535, 65535, 65536, 0, 0, 1);
    drive_corners();
    run_random(50);
    drain();

    program_config(65536, 0, 0, 0, 65535, 65535, 65535);
    drive_corners();
    run_random(40);
    drain();

    for (ph = 0; ph < 5; ph++) begin
      program_config($urandom_range(0, 4000) - 2000, $urandom_range(200, 320),
                     $urandom_range(192, 480), $urandom_range(1500, 20000),
                     $urandom_range(0, 12), $urandom_range(0, 12),
                     (ph == 0) ? 2 : $urandom_range(1, 40));
      run_random(60);
      drain();
    end

    // Hold the eyes lost long enough to drive the blink counter into saturation.
    program_config(0, 256, 256, 6554, 0, 10, 64);
    steady = 1'b1;
    repeat (SOAK_ITEMS) drive_sample(random_sample(RUN_BLINK));
    drive_sample(random_sample(RUN_FIXATE));
    drain();
    steady = 1'b0;

    repeat (16) @(posedge clk);
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/gfm_pkg.sv
src/gfm_regs.sv
src/gfm_front.sv
src/gfm_queue.sv
src/gfm_back.sv
src/gaze_fixation_monitor_top.sv
src/gfm_checker.sv
verif/gfm_status_scoreboard.sv
verif/tb_gaze_fixation_monitor_top.sv
